[sv/plgt_pkg.sv]
// ----------------------------------------------------------------------------
// plgt_pkg: shared types and constants of the peak limiter gain tracker
// fixed point formats, register indexes and the controller state type
// ----------------------------------------------------------------------------
`default_nettype none

package plgt_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 24;
  localparam int COEFF_W  = 24;
  localparam int CH_W     = 3;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 24;
  localparam int PROD_W   = GAIN_W + COEFF_W;

  // unity gain in q1.23
  localparam logic [GAIN_W-1:0] UNITY = 24'h800000;

  // reset value of the ceiling register
  localparam logic [GAIN_W-1:0] CEILING_RST = 24'h800000;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ENABLE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CEILING = 2'd1;
  localparam logic [CFG_AW-1:0] REG_RELEASE = 2'd2;

  // divider: two quotient bits per cycle, 24 bits in all
  localparam int DIV_ITERS = 12;
  localparam int DIV_CNT_W = 4;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_REL   = 7'b0001000,
    ST_RELW  = 7'b0010000,
    ST_SCALE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

[sv/plgt_if.sv]
// ----------------------------------------------------------------------------
// plgt_if: request and result channels of the peak limiter gain tracker
// valid/ready handshake with the payload fields of each channel
// ----------------------------------------------------------------------------
`default_nettype none

interface plgt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [plgt_pkg::SAMPLE_W-1:0] sample_in;
  logic        [plgt_pkg::CH_W-1:0]     channel_sel;

  modport source (output valid, output sample_in, output channel_sel, input ready);
  modport sink   (input valid, input sample_in, input channel_sel, output ready);
endinterface

interface plgt_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [plgt_pkg::SAMPLE_W-1:0] sample_out;
  logic        [plgt_pkg::GAIN_W-1:0]   gain_now;
  logic                                 over_ceiling;

  modport source (output valid, output sample_out, output gain_now, output over_ceiling,
                  input ready);
  modport sink   (input valid, input sample_out, input gain_now, input over_ceiling,
                  output ready);
endinterface

`default_nettype wire

[sv/peak_limiter_gain_tracker_unit.sv]
// ----------------------------------------------------------------------------
// peak_limiter_gain_tracker_unit: per-channel peak limiter
// instant attack to ceiling/magnitude, exponential release toward unity,
// one gain per channel held in a small synchronous memory
// ----------------------------------------------------------------------------
//
//  channel  | dir | fields                                   | handshake
//  ---------+-----+------------------------------------------+-----------
//  in_req   | in  | sample_in[23:0] s, channel_sel[2:0]      | valid/ready
//  out_res  | out | sample_out[23:0] s, gain_now[23:0],      | valid/ready
//           |     | over_ceiling                             |
//  cfg      | in  | cfg_we, cfg_addr[1:0], cfg_wdata[23:0]   | write only
//
//  one request at a time: accept, gain memory read, then one of
//    pass through     : straight to the done state
//    gain held        : scale (one multiply), then done
//    release          : rel, relw, scale, done (two passes through the shared multiplier)
//    attack           : div in the radix-4 divider, then scale and done
//  and from done back to idle before the next accept
//  a finished result sits in the output register; the next request is taken
//  while it waits, and the controller only stalls in its last state when the
//  output register is still full
//  reset (synchronous, rst_n low) clears the gain valid bits, so every
//  channel reads as unity gain until its entry is written
// ----------------------------------------------------------------------------
`default_nettype none

module peak_limiter_gain_tracker_unit #(
  parameter int CHANNELS = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  plgt_in_if.sink                          in_req,
  plgt_out_if.source                       out_res,
  input  wire                              cfg_we,
  input  wire  [plgt_pkg::CFG_AW-1:0]      cfg_addr,
  input  wire  [plgt_pkg::CFG_DW-1:0]      cfg_wdata
);

  // gain memory address width, at least one bit
  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = 2 ** AW;

  localparam int SW = plgt_pkg::SAMPLE_W;
  localparam int GW = plgt_pkg::GAIN_W;
  localparam int PW = plgt_pkg::PROD_W;

  // rounding constant, half an lsb of the q1.23 product
  localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (GW - 2);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic          enable_r;
  logic [GW-1:0] ceiling_r;
  logic [GW-1:0] coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      ceiling_r <= plgt_pkg::CEILING_RST;
      coeff_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        plgt_pkg::REG_ENABLE:  enable_r  <= cfg_wdata[0];
        plgt_pkg::REG_CEILING: ceiling_r <= cfg_wdata[GW-1:0];
        plgt_pkg::REG_RELEASE: coeff_r   <= cfg_wdata[GW-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // controller state and request capture
  // --------------------------------------------------------------------------
  plgt_pkg::state_t state_r, state_nxt;

  logic                     in_fire;
  logic                     out_fire;
  logic                     done_load;

  logic [SW-1:0]            samp_r;     // raw input sample bits
  logic                     neg_r;      // input sample is negative
  logic [SW-1:0]            mag_r;      // |sample|, up to 2^23
  logic [plgt_pkg::CH_W-1:0] ch_r;

  logic [SW-1:0]            in_mag;
  logic [AW-1:0]            rd_addr;

  assign in_req.ready = (state_r == plgt_pkg::ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  // magnitude of the most negative sample comes out as 2^23, exactly
  assign in_mag  = in_req.sample_in[SW-1] ? (~in_req.sample_in + SW'(1))
                                          : in_req.sample_in;
  assign rd_addr = AW'(in_req.channel_sel);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      samp_r <= in_req.sample_in;
      neg_r  <= in_req.sample_in[SW-1];
      mag_r  <= in_mag;
      ch_r   <= in_req.channel_sel;
    end
  end

  // --------------------------------------------------------------------------
  // gain memory: read on accept, written back once the item completes
  // unless it was passed through. only one item is in flight, so a read
  // never overlaps a pending write to the same entry
  // --------------------------------------------------------------------------
  logic [GW-1:0]    gain_mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [GW-1:0]    rd_data_r;
  logic             rd_valid_r;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [GW-1:0]    g_r;
  logic             pass_r;

  assign wr_addr = AW'(ch_r);
  assign wr_en   = done_load && !pass_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r  <= gain_mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
    if (wr_en) begin
      gain_mem[wr_addr] <= g_r;
    end
  end

  // an entry never written reads as unity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // decode after the memory read
  // --------------------------------------------------------------------------
  logic          in_range;
  logic          active;
  logic [GW-1:0] gain_cur;

  assign in_range = (int'(ch_r) < CHANNELS);
  assign active   = enable_r && (ceiling_r != '0);
  assign gain_cur = rd_valid_r ? rd_data_r : plgt_pkg::UNITY;

  // --------------------------------------------------------------------------
  // radix-4 restoring divider: ceiling * 2^24 / magnitude
  // remainder starts at the ceiling, which is below the divisor; the final
  // quotient is shifted down one bit to give floor(ceiling * 2^23 / mag)
  // --------------------------------------------------------------------------
  logic [GW-1:0]                  rem_r;
  logic [GW-1:0]                  quo_r;
  logic [plgt_pkg::DIV_CNT_W-1:0] cnt_r;

  logic [GW:0]   t1, t2;
  logic          ge1, ge2;
  logic [GW-1:0] r1, r2;
  logic [GW:0]   r1_full, r2_full;
  logic [GW-1:0] quo_nxt;
  logic [GW-1:0] q_att;
  logic          div_last;

  always_comb begin
    t1      = {rem_r, 1'b0};
    ge1     = (t1 >= {1'b0, mag_r});
    r1_full = ge1 ? (t1 - {1'b0, mag_r}) : t1;
    r1      = r1_full[GW-1:0];
    t2      = {r1, 1'b0};
    ge2     = (t2 >= {1'b0, mag_r});
    r2_full = ge2 ? (t2 - {1'b0, mag_r}) : t2;
    r2      = r2_full[GW-1:0];
    quo_nxt = {quo_r[GW-3:0], ge1, ge2};
    q_att   = {1'b0, quo_nxt[GW-1:1]};
  end

  assign div_last = (cnt_r == plgt_pkg::DIV_CNT_W'(plgt_pkg::DIV_ITERS - 1));

  // --------------------------------------------------------------------------
  // shared multiplier: release decay, then output scaling
  // --------------------------------------------------------------------------
  logic [PW-1:0] prod_r;
  logic [GW-1:0] mul_a, mul_b;
  logic [GW-1:0] deficit;
  logic [PW-1:0] rounded;
  logic [SW-1:0] scaled_mag;
  logic [SW-1:0] scaled;

  assign deficit = plgt_pkg::UNITY - g_r;

  always_comb begin
    if (state_r == plgt_pkg::ST_REL) begin
      mul_a = deficit;
      mul_b = coeff_r;
    end else begin
      mul_a = mag_r;
      mul_b = g_r;
    end
  end

  // round half away from zero on the magnitude, then restore the sign;
  // full scale at unity gain reaches 2^23, so bit 46 is kept
  assign rounded    = prod_r + ROUND_HALF;
  assign scaled_mag = rounded[PW-2:GW-1];
  assign scaled     = neg_r ? (~scaled_mag + SW'(1)) : scaled_mag;

  // --------------------------------------------------------------------------
  // controller
  // --------------------------------------------------------------------------
  logic out_valid_r;

  assign done_load = (state_r == plgt_pkg::ST_DONE) && (!out_valid_r || out_res.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plgt_pkg::ST_IDLE:  if (in_fire) state_nxt = plgt_pkg::ST_READ;
      plgt_pkg::ST_READ: begin
        if (!in_range || !active) begin
          state_nxt = plgt_pkg::ST_DONE;
        end else if (mag_r > ceiling_r) begin
          state_nxt = plgt_pkg::ST_DIV;
        end else if (gain_cur < plgt_pkg::UNITY) begin
          state_nxt = plgt_pkg::ST_REL;
        end else begin
          state_nxt = plgt_pkg::ST_SCALE;
        end
      end
      plgt_pkg::ST_DIV:   if (div_last) state_nxt = plgt_pkg::ST_SCALE;
      plgt_pkg::ST_REL:   state_nxt = plgt_pkg::ST_RELW;
      plgt_pkg::ST_RELW:  state_nxt = plgt_pkg::ST_SCALE;
      plgt_pkg::ST_SCALE: state_nxt = plgt_pkg::ST_DONE;
      plgt_pkg::ST_DONE:  if (done_load) state_nxt = plgt_pkg::ST_IDLE;
      default:            state_nxt = plgt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plgt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  logic over_r;

  always_ff @(posedge clk) begin
    case (state_r)
      plgt_pkg::ST_READ: begin
        g_r    <= in_range ? gain_cur : plgt_pkg::UNITY;
        pass_r <= !in_range || !active;
        over_r <= in_range && active && (mag_r > ceiling_r);
        rem_r  <= ceiling_r;
        quo_r  <= '0;
        cnt_r  <= '0;
      end
      plgt_pkg::ST_DIV: begin
        rem_r <= r2;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + plgt_pkg::DIV_CNT_W'(1);
        // attack never raises the gain
        if (div_last && (q_att < g_r)) begin
          g_r <= q_att;
        end
      end
      plgt_pkg::ST_REL:   prod_r <= mul_a * mul_b;
      plgt_pkg::ST_RELW:  g_r    <= plgt_pkg::UNITY - prod_r[PW-1:plgt_pkg::COEFF_W];
      plgt_pkg::ST_SCALE: prod_r <= mul_a * mul_b;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic [SW-1:0] out_samp_r;
  logic [GW-1:0] out_gain_r;
  logic          out_over_r;

  assign out_fire = out_valid_r && out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      out_samp_r <= pass_r ? samp_r : scaled;
      out_gain_r <= g_r;
      out_over_r <= over_r;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.sample_out   = out_samp_r;
  assign out_res.gain_now     = out_gain_r;
  assign out_res.over_ceiling = out_over_r;

endmodule

`default_nettype wire

[sv/plgt_checker.sv]
// ----------------------------------------------------------------------------
// plgt_checker: port-level checks of the peak limiter gain tracker
// bound to the top level, watches the request and result channels
// ----------------------------------------------------------------------------
`default_nettype none

module plgt_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_valid,
  input wire                              in_ready,
  input wire                              out_valid,
  input wire                              out_ready,
  input wire [plgt_pkg::SAMPLE_W-1:0]     sample_out,
  input wire [plgt_pkg::GAIN_W-1:0]       gain_now,
  input wire                              over_ceiling
);

  // a held result keeps its payload while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(gain_now)
      && $stable(over_ceiling))
    else $error("result changed while stalled");

  // one request in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // gain never exceeds unity
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> gain_now <= plgt_pkg::UNITY)
    else $error("gain above unity");

  // an attack always leaves the gain below unity
  a_attack_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && over_ceiling |-> gain_now < plgt_pkg::UNITY)
    else $error("attack left unity gain");

  // nothing shows on the result channel right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind peak_limiter_gain_tracker_unit plgt_checker u_plgt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .sample_out   (out_res.sample_out),
  .gain_now     (out_res.gain_now),
  .over_ceiling (out_res.over_ceiling)
);

`default_nettype wire
